/* rtl/assert_macros.svh */
// Assertion macros shared by the zone histogram RTL.
// Define NO_ASSERTIONS to compile the checks out; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check a property on every clock edge outside reset.
`define ZH_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Check that a condition never holds outside reset.
`define ZH_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define ZH_ASSERT(lbl, clk, rstn, prop, msg)
`define ZH_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

/* rtl/zhgp_pkg.sv */
// Shared types and constants of the zone histogram block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package zhgp_pkg;

  localparam int unsigned CountWidthDef = 16;
  localparam int unsigned QueueDepth    = 4;
  localparam int unsigned GridZones     = 16;
  localparam int unsigned PolarZones    = 36;
  localparam int unsigned GridTables    = 3;
  localparam int unsigned PolarTables   = 2;
  localparam int unsigned NumCells      = GridZones * GridTables + PolarZones * PolarTables;
  localparam int unsigned CellAw        = $clog2(NumCells);
  localparam int unsigned PolarBase     = GridZones * GridTables;
  localparam int unsigned ZoneW         = 6;
  localparam int unsigned OutCountW     = 16;

  // Squared span used when the tracked area collapses to a point: 1.5^2 * 2^32.
  localparam logic [33:0] ZeroSpanSq = 34'd9663676416;

  typedef enum logic [1:0] {
    FUNC_RECORD = 2'd0,
    FUNC_QUERY  = 2'd1,
    FUNC_CLEAR  = 2'd2
  } func_e;

  typedef enum logic [2:0] {
    TBL_GRID_POS  = 3'd0,
    TBL_GRID_MOT  = 3'd1,
    TBL_GRID_ACC  = 3'd2,
    TBL_POLAR_POS = 3'd3,
    TBL_POLAR_MOT = 3'd4
  } table_e;

  typedef enum logic [2:0] {
    CFG_CENTER_X = 3'd0,
    CFG_CENTER_Y = 3'd1,
    CFG_LOWER_X  = 3'd2,
    CFG_LOWER_Y  = 3'd3,
    CFG_UPPER_X  = 3'd4,
    CFG_UPPER_Y  = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    OP_RECORD,
    OP_QUERY,
    OP_CLEAR,
    OP_NONE
  } op_e;

  typedef enum logic {
    ST_IDLE,
    ST_UPDATE
  } back_state_e;

  typedef struct packed {
    op_e               op;
    logic [CellAw-1:0] addr;
    logic [ZoneW-1:0]  zone;
  } q_entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  typedef struct packed {
    logic [15:0] center_x;
    logic [15:0] center_y;
    logic [15:0] lower_x;
    logic [15:0] lower_y;
    logic [15:0] upper_x;
    logic [15:0] upper_y;
  } zone_cfg_t;

endpackage

/* rtl/zhgp_front.sv */
// Front end: classifies a transaction and maps its point to a counter cell.
// Three register stages (offsets, squares, sector and radius terms). Uses zhgp_pkg.
`timescale 1ns / 1ps

module zhgp_front import zhgp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [1:0]  func_i,
  input  logic [2:0]  table_sel_i,
  input  logic [15:0] point_x_i,
  input  logic [15:0] point_y_i,
  input  zone_cfg_t   cfg_i,
  output logic        push_o,
  output q_entry_t    entry_o
);

  typedef struct packed {
    logic xpos;
    logic xneg;
    logic ypos;
    logic yneg;
  } quad_t;

  // Stage 1: offsets and classification
  logic [16:0]       dx, dy;
  logic [15:0]       ax, ay, spx, spy;
  op_e               op;
  logic [CellAw-1:0] base;
  logic              polar;
  quad_t             quad;

  logic              v1_q, v2_q, v3_q;
  op_e               op1_q, op2_q, op3_q;
  logic              pol1_q, pol2_q, pol3_q;
  logic [CellAw-1:0] base1_q, base2_q, base3_q;
  logic [3:0]        gz1_q, gz2_q, gz3_q;
  quad_t             quad1_q, quad2_q;
  logic [15:0]       ax1_q, ay1_q, spx1_q, spy1_q;

  // Stage 2: squares
  logic [31:0]       ax2_q, ay2_q, sx2_q, sy2_q;

  // Stage 3: sector, r^2 and span^2
  logic [33:0]       ax2x3, ay2x3;
  logic [1:0]        band;
  logic [3:0]        sector;
  logic [32:0]       r2, span_raw;
  logic [33:0]       span2;
  logic [3:0]        sector3_q;
  logic [32:0]       r2_q;
  logic [33:0]       span2_q;

  // Stage 4: ring and address
  logic [36:0]       r9;
  logic [1:0]        ring;
  logic [ZoneW-1:0]  pzone, zone;

  always_comb begin
    dx    = {1'b0, point_x_i} - {1'b0, cfg_i.center_x};
    dy    = {1'b0, point_y_i} - {1'b0, cfg_i.center_y};
    ax    = dx[16] ? 16'(-dx) : dx[15:0];
    ay    = dy[16] ? 16'(-dy) : dy[15:0];
    spx   = (cfg_i.upper_x >= cfg_i.lower_x) ? cfg_i.upper_x - cfg_i.lower_x
                                             : cfg_i.lower_x - cfg_i.upper_x;
    spy   = (cfg_i.upper_y >= cfg_i.lower_y) ? cfg_i.upper_y - cfg_i.lower_y
                                             : cfg_i.lower_y - cfg_i.upper_y;
    quad.xpos = !dx[16] && (dx != '0);
    quad.xneg = dx[16];
    quad.ypos = !dy[16] && (dy != '0);
    quad.yneg = dy[16];

    case (func_i)
      FUNC_RECORD: op = OP_RECORD;
      FUNC_QUERY:  op = OP_QUERY;
      FUNC_CLEAR:  op = OP_CLEAR;
      default:     op = OP_NONE;
    endcase
    if ((op == OP_RECORD || op == OP_QUERY) &&
        !(table_sel_i inside {[TBL_GRID_POS:TBL_POLAR_MOT]})) begin
      op = OP_NONE;
    end

    polar = table_sel_i inside {TBL_POLAR_POS, TBL_POLAR_MOT};
    case (table_sel_i)
      TBL_GRID_POS:  base = '0;
      TBL_GRID_MOT:  base = CellAw'(GridZones);
      TBL_GRID_ACC:  base = CellAw'(2 * GridZones);
      TBL_POLAR_POS: base = CellAw'(PolarBase);
      TBL_POLAR_MOT: base = CellAw'(PolarBase + PolarZones);
      default:       base = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= accept_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    op1_q   <= op;
    pol1_q  <= polar;
    base1_q <= base;
    gz1_q   <= {point_y_i[15:14], point_x_i[15:14]};
    quad1_q <= quad;
    ax1_q   <= ax;
    ay1_q   <= ay;
    spx1_q  <= spx;
    spy1_q  <= spy;

    op2_q   <= op1_q;
    pol2_q  <= pol1_q;
    base2_q <= base1_q;
    gz2_q   <= gz1_q;
    quad2_q <= quad1_q;
    ax2_q   <= ax1_q * ax1_q;
    ay2_q   <= ay1_q * ay1_q;
    sx2_q   <= spx1_q * spx1_q;
    sy2_q   <= spy1_q * spy1_q;

    op3_q     <= op2_q;
    pol3_q    <= pol2_q;
    base3_q   <= base2_q;
    gz3_q     <= gz2_q;
    sector3_q <= sector;
    r2_q      <= r2;
    span2_q   <= span2;
  end

  // Sector: 30 degree band within the quadrant, then fold by quadrant.
  // Points on an axis take the higher sector; the center itself is sector zero.
  always_comb begin
    ax2x3 = {2'b0, ax2_q} + {1'b0, ax2_q, 1'b0};
    ay2x3 = {2'b0, ay2_q} + {1'b0, ay2_q, 1'b0};
    if (ay2x3 < {2'b0, ax2_q}) begin
      band = 2'd0;
    end else if ({2'b0, ay2_q} < ax2x3) begin
      band = 2'd1;
    end else begin
      band = 2'd2;
    end

    if (quad2_q.xpos) begin
      sector = quad2_q.yneg ? 4'd11 - {2'b0, band} : {2'b0, band};
    end else if (quad2_q.xneg) begin
      if (quad2_q.ypos) begin
        sector = 4'd5 - {2'b0, band};
      end else if (!quad2_q.yneg) begin
        sector = 4'd6;
      end else begin
        sector = 4'd6 + {2'b0, band};
      end
    end else begin
      sector = quad2_q.ypos ? 4'd3 : (quad2_q.yneg ? 4'd9 : 4'd0);
    end

    r2       = {1'b0, ax2_q} + {1'b0, ay2_q};
    span_raw = {1'b0, sx2_q} + {1'b0, sy2_q};
    span2    = (span_raw == '0) ? ZeroSpanSq : {1'b0, span_raw};
  end

  // Ring: compare 9*r^2 against span^2 and 4*span^2, saturate at the outer ring.
  always_comb begin
    r9 = {4'b0, r2_q} + {1'b0, r2_q, 3'b0};
    if (r9 < {3'b0, span2_q}) begin
      ring = 2'd0;
    end else if (r9 < {1'b0, span2_q, 2'b0}) begin
      ring = 2'd1;
    end else begin
      ring = 2'd2;
    end
    case (ring)
      2'd0:    pzone = {2'b0, sector3_q};
      2'd1:    pzone = {2'b0, sector3_q} + 6'd12;
      default: pzone = {2'b0, sector3_q} + 6'd24;
    endcase
    zone = pol3_q ? pzone : {2'b0, gz3_q};

    push_o        = v3_q;
    entry_o.op    = op3_q;
    entry_o.zone  = zone;
    entry_o.addr  = base3_q + CellAw'(zone);
  end

endmodule

/* rtl/zhgp_fifo.sv */
// Short queue between the front end and the counter back end.
// Holds classified transactions; uses zhgp_pkg for the entry and status types.
`timescale 1ns / 1ps

module zhgp_fifo import zhgp_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  q_entry_t  push_data_i,
  input  logic      pop_i,
  output q_entry_t  head_o,
  output q_status_t status_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  q_entry_t          slots_q [Depth];
  logic [PtrW-1:0]   wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              do_push, do_pop;

  always_comb begin
    do_push = push_i && (cnt_q != CntW'(Depth));
    do_pop  = pop_i && (cnt_q != '0);
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    cnt_d = cnt_q + CntW'(do_push) - CntW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wptr_q] <= push_data_i;
    end
  end

  assign head_o         = slots_q[rptr_q];
  assign status_o.empty = (cnt_q == '0);
  assign status_o.full  = (cnt_q == CntW'(Depth));

endmodule

/* rtl/zhgp_back.sv */
// Back end: counter memory with read-modify-write sequencer and result register.
// Uses zhgp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module zhgp_back import zhgp_pkg::*; #(
  parameter int unsigned CountWidth = CountWidthDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  q_status_t            q_status_i,
  input  q_entry_t             head_i,
  output logic                 pop_o,
  output logic                 result_valid_o,
  output logic [ZoneW-1:0]     zone_index_o,
  output logic [OutCountW-1:0] zone_count_o
);

  back_state_e           state_q, state_d;
  q_entry_t              cur_q;
  logic [CountWidth-1:0] mem_q [NumCells];
  logic [CountWidth-1:0] rd_q;
  logic                  rd_vld_q;
  logic [NumCells-1:0]   valid_q;

  logic [CountWidth-1:0]           cnt_cur, cnt_new;
  logic [CountWidth+OutCountW-1:0] cnt_ext;
  logic [OutCountW-1:0]            cnt_sat;
  logic                            mem_we, clear_all, fire, has_zone;

  logic                  res_valid_q;
  logic [ZoneW-1:0]      res_zone_q;
  logic [OutCountW-1:0]  res_count_q;

  always_comb begin
    case (state_q)
      ST_IDLE:   state_d = q_status_i.empty ? ST_IDLE : ST_UPDATE;
      ST_UPDATE: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    pop_o     = (state_q == ST_IDLE) && !q_status_i.empty;
    fire      = (state_q == ST_UPDATE);
    has_zone  = (cur_q.op == OP_RECORD) || (cur_q.op == OP_QUERY);
    mem_we    = fire && (cur_q.op == OP_RECORD);
    clear_all = fire && (cur_q.op == OP_CLEAR);
    cnt_cur   = rd_vld_q ? rd_q : '0;
    // saturate at the top of the counter range
    cnt_new   = ((cur_q.op == OP_RECORD) && (cnt_cur != '1)) ? cnt_cur + 1'b1 : cnt_cur;
    cnt_ext   = {{OutCountW{1'b0}}, cnt_new};
    cnt_sat   = (cnt_ext > (CountWidth + OutCountW)'({OutCountW{1'b1}})) ?
                {OutCountW{1'b1}} : cnt_ext[OutCountW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= fire;
      if (clear_all) begin
        valid_q <= '0;
      end else if (mem_we) begin
        valid_q[cur_q.addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[cur_q.addr] <= cnt_new;
    end
    if (pop_o) begin
      rd_q     <= mem_q[head_i.addr];
      rd_vld_q <= valid_q[head_i.addr];
      cur_q    <= head_i;
    end
    if (fire) begin
      res_zone_q  <= has_zone ? cur_q.zone : '0;
      res_count_q <= has_zone ? cnt_sat : '0;
    end
  end

  assign result_valid_o = res_valid_q;
  assign zone_index_o   = res_zone_q;
  assign zone_count_o   = res_count_q;

  `ZH_ASSERT_NEVER(a_rec_nonzero, clk_i, rst_ni, mem_we && (cnt_new == '0), "record wrote zero")
  `ZH_ASSERT(a_res_after_upd, clk_i, rst_ni, res_valid_q |-> $past(state_q == ST_UPDATE), "stray result")
  `ZH_ASSERT(a_clear_valid, clk_i, rst_ni, clear_all |=> (valid_q == '0), "clear left counters")

endmodule

/* rtl/zone_histogram_grid_and_polar.sv */
// Top level of the spatial zone histogram (grid and polar layouts).
// Instantiates zhgp_front, zhgp_fifo and zhgp_back; uses zhgp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// A transaction is taken at a clock edge where start is high and busy is low. Each
// transaction returns exactly one result, shown on zone_index_o/zone_count_o for a
// single cycle with result_valid_o high; the receiver cannot stall it, so sample it
// then. A transaction passes through three front-end stages (offsets, squares, sector and
// ring terms), one queue slot, and a read-modify-write in the back end (read on
// pop, write in the update state). The back end takes a new transaction only once
// the read-then-write of the last one is done on the single-port counter memory.
// Up to four transactions may wait ahead of the back end; busy is high while all
// four credits are held, so a burst of four is accepted back to back. The counters
// reset (and clear) through per-entry valid bits, so no clearing sweep follows
// reset. Write the configuration registers only while no transaction is
// outstanding; cfg_ready_o is always high and indexes 6 and 7 are ignored.
module zone_histogram_grid_and_polar import zhgp_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = CountWidthDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // transaction command port
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           func_i,
  input  logic [2:0]           table_sel_i,
  input  logic [15:0]          point_x_i,
  input  logic [15:0]          point_y_i,
  // result port
  output logic                 result_valid_o,
  output logic [ZoneW-1:0]     zone_index_o,
  output logic [OutCountW-1:0] zone_count_o,
  // configuration write port
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [2:0]           cfg_index_i,
  input  logic [15:0]          cfg_data_i
);

  localparam int unsigned CredW = $clog2(QueueDepth + 1);

  zone_cfg_t        cfg_q, cfg_d;
  logic [CredW-1:0] inflight_q, inflight_d;
  logic             accept;
  logic             q_push, q_pop;
  q_entry_t         q_in, q_head;
  q_status_t        q_status;

  // Hold a credit for each transaction from acceptance until the back end pops it,
  // so the front end never stalls and the queue never overflows.
  assign accept      = start && !busy;
  assign busy        = (inflight_q == CredW'(QueueDepth));
  assign cfg_ready_o = 1'b1;

  always_comb begin
    inflight_d = inflight_q + CredW'(accept) - CredW'(q_pop);
  end

  // Configuration registers
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_CENTER_X: cfg_d.center_x = cfg_data_i;
        CFG_CENTER_Y: cfg_d.center_y = cfg_data_i;
        CFG_LOWER_X:  cfg_d.lower_x  = cfg_data_i;
        CFG_LOWER_Y:  cfg_d.lower_y  = cfg_data_i;
        CFG_UPPER_X:  cfg_d.upper_x  = cfg_data_i;
        CFG_UPPER_Y:  cfg_d.upper_y  = cfg_data_i;
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.center_x <= 16'd32768;
      cfg_q.center_y <= 16'd32768;
      cfg_q.lower_x  <= 16'd0;
      cfg_q.lower_y  <= 16'd0;
      cfg_q.upper_x  <= 16'd65535;
      cfg_q.upper_y  <= 16'd65535;
      inflight_q     <= '0;
    end else begin
      cfg_q      <= cfg_d;
      inflight_q <= inflight_d;
    end
  end

  // Front end: classify and map to a counter cell.
  zhgp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .func_i      (func_i),
    .table_sel_i (table_sel_i),
    .point_x_i   (point_x_i),
    .point_y_i   (point_y_i),
    .cfg_i       (cfg_q),
    .push_o      (q_push),
    .entry_o     (q_in)
  );

  // Decouple the front end from the counter sequencer.
  zhgp_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_in),
    .pop_i       (q_pop),
    .head_o      (q_head),
    .status_o    (q_status)
  );

  // Back end: update or read the counter and register the result.
  zhgp_back #(
    .CountWidth (COUNT_WIDTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_status_i     (q_status),
    .head_i         (q_head),
    .pop_o          (q_pop),
    .result_valid_o (result_valid_o),
    .zone_index_o   (zone_index_o),
    .zone_count_o   (zone_count_o)
  );

  `ZH_ASSERT(a_q_no_overflow, clk_i, rst_ni, q_push |-> !q_status.full, "queue overflow")
  `ZH_ASSERT(a_q_no_underflow, clk_i, rst_ni, q_pop |-> !q_status.empty, "pop from empty queue")
  `ZH_ASSERT(a_busy_after_start, clk_i, rst_ni, $rose(busy) |-> $past(start), "busy rose without start")

endmodule
